>>> design/dtyp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtyp_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int ROT_STAGES_DEF = 16;

  // normalized operands stay below 2^NORM_BITS
  localparam int NORM_BITS   = 30;
  localparam int TABLE_LEN   = 24;

  localparam int ANGLE_W     = 16;
  localparam int PITCH_W     = 15;
  localparam int CONE_W      = 16;

  // CORDIC angle accumulator, 1/65536 degree
  localparam int Z_W         = 25;
  localparam int FRAC_SHIFT  = 9;
  localparam logic signed [Z_W-1:0] ROUND_BIAS = 25'sd256;
  localparam logic signed [Z_W-1:0] DEG90_FINE = 25'sd5898240;

  // 1/128 degree
  localparam int QUARTER_TURN = 11520;
  localparam int HALF_TURN    = 23040;
  localparam int FULL_TURN    = 46080;

  localparam logic [CONE_W-1:0] CONE_RESET = 16'd11520;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] cp;
    logic signed [ANGLE_W-1:0] cy;
    logic                      vert;
    logic                      dy_neg;
  } dtyp_tag_t;

  // atan(2^-i) in 1/65536 degree, rounded
  function automatic logic signed [Z_W-1:0] atan_fine(input int idx);
    logic signed [Z_W-1:0] a;
    unique case (idx)
      0:       a = 25'sd2949120;
      1:       a = 25'sd1740967;
      2:       a = 25'sd919879;
      3:       a = 25'sd466945;
      4:       a = 25'sd234379;
      5:       a = 25'sd117304;
      6:       a = 25'sd58666;
      7:       a = 25'sd29335;
      8:       a = 25'sd14668;
      9:       a = 25'sd7334;
      10:      a = 25'sd3667;
      11:      a = 25'sd1833;
      12:      a = 25'sd917;
      13:      a = 25'sd458;
      14:      a = 25'sd229;
      15:      a = 25'sd115;
      16:      a = 25'sd57;
      17:      a = 25'sd29;
      18:      a = 25'sd14;
      19:      a = 25'sd7;
      20:      a = 25'sd4;
      21:      a = 25'sd2;
      22:      a = 25'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

>>> design/dtyp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dtyp_in_if #(parameter int COORD_BITS = dtyp_pkg::COORD_BITS_DEF) ();
  logic                           valid;
  logic                           ready;
  logic signed [COORD_BITS-1:0]   target_x;
  logic signed [COORD_BITS-1:0]   target_y;
  logic signed [COORD_BITS-1:0]   target_z;
  logic signed [COORD_BITS-1:0]   viewer_x;
  logic signed [COORD_BITS-1:0]   viewer_y;
  logic signed [COORD_BITS-1:0]   viewer_z;
  logic signed [dtyp_pkg::ANGLE_W-1:0] current_pitch;
  logic signed [dtyp_pkg::ANGLE_W-1:0] current_yaw;

  modport source (output valid, target_x, target_y, target_z, viewer_x, viewer_y,
                  viewer_z, current_pitch, current_yaw, input ready);
  modport sink   (input valid, target_x, target_y, target_z, viewer_x, viewer_y,
                  viewer_z, current_pitch, current_yaw, output ready);
endinterface

interface dtyp_out_if ();
  logic                                valid;
  logic                                ready;
  logic signed [dtyp_pkg::ANGLE_W-1:0] yaw_out;
  logic signed [dtyp_pkg::PITCH_W-1:0] pitch_out;
  logic                                in_cone;

  modport source (output valid, yaw_out, pitch_out, in_cone, input ready);
  modport sink   (input valid, yaw_out, pitch_out, in_cone, output ready);
endinterface

interface dtyp_cfg_if ();
  logic                         valid;
  logic                         ready;
  logic [dtyp_pkg::CONE_W-1:0]  cone_angle;

  modport source (output valid, cone_angle, input ready);
  modport sink   (input valid, cone_angle, output ready);
endinterface

`default_nettype wire

>>> design/dtyp_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One result bit of a restoring integer square root.
module dtyp_sqrt_cell #(
  parameter int RW = 26
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [RW+2:0]   rem_in,
  input  wire logic [RW-1:0]   root_in,
  input  wire logic [2*RW-1:0] rad_in,
  output logic [RW+2:0]        rem_out,
  output logic [RW-1:0]        root_out,
  output logic [2*RW-1:0]      rad_out
);

  localparam int RMW = RW + 3;

  logic [RMW-1:0]  rem_sh;
  logic [RMW-1:0]  trial;
  logic            ge;
  logic [RMW-1:0]  rem_nxt, rem_r;
  logic [RW-1:0]   root_nxt, root_r;
  logic [2*RW-1:0] rad_nxt, rad_r;

  // remainder stays below 2^(RW+1), so its top two bits are free
  assign rem_sh   = {rem_in[RMW-3:0], rad_in[2*RW-1 -: 2]};
  assign trial    = {1'b0, root_in, 2'b01};
  assign ge       = (rem_sh >= trial);
  assign rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
  assign root_nxt = {root_in[RW-2:0], ge};
  assign rad_nxt  = {rad_in[2*RW-3:0], 2'b00};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= rad_nxt;
    end
  end

  assign rem_out  = rem_r;
  assign root_out = root_r;
  assign rad_out  = rad_r;

endmodule

`default_nettype wire

>>> design/dtyp_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One vectoring micro-rotation; STEP selects shift and table angle.
module dtyp_cordic_cell #(
  parameter int CW   = 29,
  parameter int STEP = 0
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [CW-1:0]          x_in,
  input  wire logic signed [CW-1:0]          y_in,
  input  wire logic signed [dtyp_pkg::Z_W-1:0] z_in,
  output logic signed [CW-1:0]               x_out,
  output logic signed [CW-1:0]               y_out,
  output logic signed [dtyp_pkg::Z_W-1:0]    z_out
);

  logic signed [CW-1:0]            xs, ys;
  logic signed [CW-1:0]            x_nxt, y_nxt, x_r, y_r;
  logic signed [dtyp_pkg::Z_W-1:0] z_nxt, z_r;
  logic signed [dtyp_pkg::Z_W-1:0] ang;

  assign xs  = x_in >>> STEP;
  assign ys  = y_in >>> STEP;
  assign ang = dtyp_pkg::atan_fine(STEP);

  always_comb begin
    if (y_in > 0) begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + ang;
    end else begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;

endmodule

`default_nettype wire

>>> design/direction_to_yaw_pitch_cone_test.sv
`timescale 1ns / 1ps
`default_nettype none

// Direction to yaw/pitch with view-cone test.
// in_ch  : one transfer = target point, viewer point, current pitch and yaw.
// out_ch : one transfer per input = yaw_out, pitch_out (1/128 degree), in_cone.
// cfg_ch : one transfer writes cone_angle (full cone, 1/128 degree); ready is
//          always high. Write only while no item is in flight.
// Throughput: one item per cycle while the pipeline is not frozen (see Stall).
//   The pipeline centres on a row of RW = min(COORD_BITS+1, 30) + 1
//   square-root cells (one root bit each) followed by two rows of CORDIC
//   cells (yaw and pitch, one micro-rotation each); every cell hands its
//   vector on whenever the pipeline advances.
// Reset clears all valid flags, empties the output and skid registers and
//   sets cone_angle to 11520 (90 degrees).
// Stall: the output register plus a skid register take results; the whole
//   pipeline freezes and in_ch.ready drops only once the skid register holds
//   a result, so one waiting result never blocks input by itself.
module direction_to_yaw_pitch_cone_test #(
  parameter int COORD_BITS      = dtyp_pkg::COORD_BITS_DEF,
  parameter int ROTATION_STAGES = dtyp_pkg::ROT_STAGES_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  dtyp_in_if.sink   in_ch,
  dtyp_out_if.source out_ch,
  dtyp_cfg_if.sink  cfg_ch
);

  localparam int D   = COORD_BITS + 1;                          // difference width
  localparam int MW  = (D < dtyp_pkg::NORM_BITS) ? D : dtyp_pkg::NORM_BITS;
  localparam int RW  = MW + 1;                                  // root bits
  localparam int NW  = 2 * RW;                                  // radicand bits
  localparam int PW  = (RW > D) ? RW : D;                       // shift search width
  localparam int SW  = $clog2(PW + 1);
  localparam int IW  = (PW < dtyp_pkg::NORM_BITS) ? PW : dtyp_pkg::NORM_BITS;
  localparam int CW  = IW + 3;                                  // CORDIC gain headroom
  localparam int ROT = ROTATION_STAGES;
  localparam int ZW  = dtyp_pkg::Z_W;
  localparam int AW  = dtyp_pkg::ANGLE_W;
  localparam int PTW = dtyp_pkg::PITCH_W;
  localparam int NST = RW + ROT + 9;                            // pipeline stages

  // ---------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------
  // least right shift that brings m below 2^30
  function automatic logic [SW-1:0] norm_shift(input logic [PW-1:0] m);
    logic [SW-1:0] s;
    s = '0;
    for (int i = dtyp_pkg::NORM_BITS; i < PW; i++) begin
      if (m[i]) s = SW'(i - dtyp_pkg::NORM_BITS + 1);
    end
    return s;
  endfunction

  // fold a 16-bit angle into [-180,180)
  function automatic logic signed [AW-1:0] wrap_cur(input logic signed [AW-1:0] v);
    logic signed [AW:0] t;
    t = (AW+1)'(v);
    if (t >= dtyp_pkg::HALF_TURN) begin
      t = t - (AW+1)'(dtyp_pkg::FULL_TURN);
    end else if (t < -dtyp_pkg::HALF_TURN) begin
      t = t + (AW+1)'(dtyp_pkg::FULL_TURN);
    end
    return AW'(t);
  endfunction

  // ---------------------------------------------------------------------
  // flow control
  // ---------------------------------------------------------------------
  logic           adv;
  logic           in_xfer;
  logic [NST-1:0] vld_r;
  logic           pv;
  logic           out_v_r, skid_v_r;
  logic           out_load;

  assign adv         = !skid_v_r;
  assign in_ch.ready = adv;
  assign in_xfer     = in_ch.valid && adv;
  assign pv          = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_xfer};
    end
  end

  // ---------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------
  logic [dtyp_pkg::CONE_W-1:0] cone_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cone_r <= dtyp_pkg::CONE_RESET;
    end else if (cfg_ch.valid) begin
      cone_r <= cfg_ch.cone_angle;
    end
  end

  // ---------------------------------------------------------------------
  // S1: differences, wrapped current angles
  // ---------------------------------------------------------------------
  logic signed [D-1:0]  s1_dx_r, s1_dy_r, s1_dz_r;
  logic signed [AW-1:0] s1_cp_r, s1_cy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx_r <= D'(in_ch.target_x) - D'(in_ch.viewer_x);
      s1_dy_r <= D'(in_ch.target_y) - D'(in_ch.viewer_y);
      s1_dz_r <= D'(in_ch.target_z) - D'(in_ch.viewer_z);
      s1_cp_r <= wrap_cur(in_ch.current_pitch);
      s1_cy_r <= wrap_cur(in_ch.current_yaw);
    end
  end

  // ---------------------------------------------------------------------
  // S2: magnitudes and signs
  // ---------------------------------------------------------------------
  logic [D-1:0]        s2_mx_r, s2_my_r, s2_mz_r;
  logic                s2_dxn_r, s2_dzn_r;
  dtyp_pkg::dtyp_tag_t s2_tag_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mx_r  <= $unsigned(s1_dx_r[D-1] ? -s1_dx_r : s1_dx_r);
      s2_my_r  <= $unsigned(s1_dy_r[D-1] ? -s1_dy_r : s1_dy_r);
      s2_mz_r  <= $unsigned(s1_dz_r[D-1] ? -s1_dz_r : s1_dz_r);
      s2_dxn_r <= s1_dx_r[D-1];
      s2_dzn_r <= s1_dz_r[D-1];
      s2_tag_r <= '{cp: s1_cp_r, cy: s1_cy_r,
                    vert: (s1_dx_r == '0) && (s1_dz_r == '0),
                    dy_neg: s1_dy_r[D-1]};
    end
  end

  // ---------------------------------------------------------------------
  // S3: common scaling of the horizontal pair (and dy)
  // ---------------------------------------------------------------------
  logic [SW-1:0]       s3_shift;
  logic [PW-1:0]       s3_mxz;
  logic [MW-1:0]       s3_sx_r, s3_sz_r;
  logic [D-1:0]        s3_my_r;
  logic                s3_dxn_r, s3_dzn_r;
  dtyp_pkg::dtyp_tag_t s3_tag_r;

  assign s3_mxz   = (s2_mx_r > s2_mz_r) ? PW'(s2_mx_r) : PW'(s2_mz_r);
  assign s3_shift = norm_shift(s3_mxz);

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_sx_r  <= MW'(s2_mx_r >> s3_shift);
      s3_sz_r  <= MW'(s2_mz_r >> s3_shift);
      s3_my_r  <= s2_my_r >> s3_shift;
      s3_dxn_r <= s2_dxn_r;
      s3_dzn_r <= s2_dzn_r;
      s3_tag_r <= s2_tag_r;
    end
  end

  // ---------------------------------------------------------------------
  // S4: squares; yaw vector is (-dx, dz)
  // ---------------------------------------------------------------------
  logic [2*MW-1:0]     s4_sqx_r, s4_sqz_r;
  logic signed [MW:0]  s4_yx_r, s4_yy_r;
  logic [D-1:0]        s4_my_r;
  dtyp_pkg::dtyp_tag_t s4_tag_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_sqx_r <= s3_sx_r * s3_sx_r;
      s4_sqz_r <= s3_sz_r * s3_sz_r;
      s4_yx_r  <= s3_dxn_r ? $signed({1'b0, s3_sx_r}) : -$signed({1'b0, s3_sx_r});
      s4_yy_r  <= s3_dzn_r ? -$signed({1'b0, s3_sz_r}) : $signed({1'b0, s3_sz_r});
      s4_my_r  <= s3_my_r;
      s4_tag_r <= s3_tag_r;
    end
  end

  // ---------------------------------------------------------------------
  // S5: radicand
  // ---------------------------------------------------------------------
  logic [NW-1:0]       s5_rad_r;
  logic signed [MW:0]  s5_yx_r, s5_yy_r;
  logic [D-1:0]        s5_my_r;
  dtyp_pkg::dtyp_tag_t s5_tag_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_rad_r <= NW'(s4_sqx_r) + NW'(s4_sqz_r);
      s5_yx_r  <= s4_yx_r;
      s5_yy_r  <= s4_yy_r;
      s5_my_r  <= s4_my_r;
      s5_tag_r <= s4_tag_r;
    end
  end

  // ---------------------------------------------------------------------
  // square-root cell row, one root bit per cell
  // ---------------------------------------------------------------------
  logic [RW+2:0] sq_rem  [RW+1];
  logic [RW-1:0] sq_root [RW+1];
  logic [NW-1:0] sq_rad  [RW+1];

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = s5_rad_r;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    dtyp_sqrt_cell #(.RW(RW)) u_cell (
      .clk      (clk),
      .en       (adv),
      .rem_in   (sq_rem[k]),
      .root_in  (sq_root[k]),
      .rad_in   (sq_rad[k]),
      .rem_out  (sq_rem[k+1]),
      .root_out (sq_root[k+1]),
      .rad_out  (sq_rad[k+1])
    );
  end

  // side data riding along the square-root row
  logic signed [MW:0]  sq_yx_r  [RW];
  logic signed [MW:0]  sq_yy_r  [RW];
  logic [D-1:0]        sq_my_r  [RW];
  dtyp_pkg::dtyp_tag_t sq_tag_r [RW];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_yx_r[0]  <= s5_yx_r;
      sq_yy_r[0]  <= s5_yy_r;
      sq_my_r[0]  <= s5_my_r;
      sq_tag_r[0] <= s5_tag_r;
      for (int k = 1; k < RW; k++) begin
        sq_yx_r[k]  <= sq_yx_r[k-1];
        sq_yy_r[k]  <= sq_yy_r[k-1];
        sq_my_r[k]  <= sq_my_r[k-1];
        sq_tag_r[k] <= sq_tag_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // P1: pitch vector (h, -dy), rescaled together
  // ---------------------------------------------------------------------
  logic [RW-1:0]       p1_h;
  logic [PW-1:0]       p1_hm;
  logic [SW-1:0]       p1_shift;
  logic [PW-1:0]       p1_hs, p1_ys;
  logic signed [IW:0]  p1_px_r, p1_py_r;
  logic signed [MW:0]  p1_yx_r, p1_yy_r;
  dtyp_pkg::dtyp_tag_t p1_tag_r;

  assign p1_h     = sq_root[RW];
  assign p1_hm    = (PW'(p1_h) > PW'(sq_my_r[RW-1])) ? PW'(p1_h) : PW'(sq_my_r[RW-1]);
  assign p1_shift = norm_shift(p1_hm);
  assign p1_hs    = PW'(p1_h) >> p1_shift;
  assign p1_ys    = PW'(sq_my_r[RW-1]) >> p1_shift;

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_px_r  <= $signed({1'b0, IW'(p1_hs)});
      p1_py_r  <= sq_tag_r[RW-1].dy_neg ? $signed({1'b0, IW'(p1_ys)})
                                        : -$signed({1'b0, IW'(p1_ys)});
      p1_yx_r  <= sq_yx_r[RW-1];
      p1_yy_r  <= sq_yy_r[RW-1];
      p1_tag_r <= sq_tag_r[RW-1];
    end
  end

  // ---------------------------------------------------------------------
  // P2: quarter-turn pre-rotation of vectors with negative x
  // ---------------------------------------------------------------------
  logic signed [CW-1:0] p2_ax, p2_ay, p2_bx, p2_by;
  logic signed [CW-1:0] p2_yx_nxt, p2_yy_nxt, p2_px_nxt, p2_py_nxt;
  logic signed [ZW-1:0] p2_yz_nxt, p2_pz_nxt;
  logic signed [CW-1:0] p2_yx_r, p2_yy_r, p2_px_r, p2_py_r;
  logic signed [ZW-1:0] p2_yz_r, p2_pz_r;
  dtyp_pkg::dtyp_tag_t  p2_tag_r;

  always_comb begin
    p2_ax = CW'(p1_yx_r);
    p2_ay = CW'(p1_yy_r);
    p2_bx = CW'(p1_px_r);
    p2_by = CW'(p1_py_r);

    p2_yx_nxt = p2_ax;
    p2_yy_nxt = p2_ay;
    p2_yz_nxt = '0;
    if (p2_ax < 0) begin
      if (p2_ay >= 0) begin
        p2_yx_nxt = p2_ay;
        p2_yy_nxt = -p2_ax;
        p2_yz_nxt = dtyp_pkg::DEG90_FINE;
      end else begin
        p2_yx_nxt = -p2_ay;
        p2_yy_nxt = p2_ax;
        p2_yz_nxt = -dtyp_pkg::DEG90_FINE;
      end
    end

    p2_px_nxt = p2_bx;
    p2_py_nxt = p2_by;
    p2_pz_nxt = '0;
    if (p2_bx < 0) begin
      if (p2_by >= 0) begin
        p2_px_nxt = p2_by;
        p2_py_nxt = -p2_bx;
        p2_pz_nxt = dtyp_pkg::DEG90_FINE;
      end else begin
        p2_px_nxt = -p2_by;
        p2_py_nxt = p2_bx;
        p2_pz_nxt = -dtyp_pkg::DEG90_FINE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_yx_r  <= p2_yx_nxt;
      p2_yy_r  <= p2_yy_nxt;
      p2_yz_r  <= p2_yz_nxt;
      p2_px_r  <= p2_px_nxt;
      p2_py_r  <= p2_py_nxt;
      p2_pz_r  <= p2_pz_nxt;
      p2_tag_r <= p1_tag_r;
    end
  end

  // ---------------------------------------------------------------------
  // CORDIC cell rows: yaw and pitch side by side
  // ---------------------------------------------------------------------
  logic signed [CW-1:0] cd_yx [ROT+1];
  logic signed [CW-1:0] cd_yy [ROT+1];
  logic signed [ZW-1:0] cd_yz [ROT+1];
  logic signed [CW-1:0] cd_px [ROT+1];
  logic signed [CW-1:0] cd_py [ROT+1];
  logic signed [ZW-1:0] cd_pz [ROT+1];

  assign cd_yx[0] = p2_yx_r;
  assign cd_yy[0] = p2_yy_r;
  assign cd_yz[0] = p2_yz_r;
  assign cd_px[0] = p2_px_r;
  assign cd_py[0] = p2_py_r;
  assign cd_pz[0] = p2_pz_r;

  for (genvar k = 0; k < ROT; k++) begin : g_cordic
    dtyp_cordic_cell #(.CW(CW), .STEP(k)) u_yaw (
      .clk   (clk),
      .en    (adv),
      .x_in  (cd_yx[k]),
      .y_in  (cd_yy[k]),
      .z_in  (cd_yz[k]),
      .x_out (cd_yx[k+1]),
      .y_out (cd_yy[k+1]),
      .z_out (cd_yz[k+1])
    );
    dtyp_cordic_cell #(.CW(CW), .STEP(k)) u_pitch (
      .clk   (clk),
      .en    (adv),
      .x_in  (cd_px[k]),
      .y_in  (cd_py[k]),
      .z_in  (cd_pz[k]),
      .x_out (cd_px[k+1]),
      .y_out (cd_py[k+1]),
      .z_out (cd_pz[k+1])
    );
  end

  dtyp_pkg::dtyp_tag_t cd_tag_r [ROT];

  always_ff @(posedge clk) begin
    if (adv) begin
      cd_tag_r[0] <= p2_tag_r;
      for (int k = 1; k < ROT; k++) begin
        cd_tag_r[k] <= cd_tag_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // F1: round to 1/128 degree (ties up), yaw offset and wrap, pitch clamp
  // ---------------------------------------------------------------------
  logic signed [ZW-1:0]  f1_yz_bias, f1_pz_bias;
  logic signed [AW-1:0]  f1_yr, f1_pr;
  logic signed [AW:0]    f1_yaw_w;
  logic signed [AW-1:0]  f1_yaw_nxt;
  logic signed [PTW-1:0] f1_pitch_nxt;
  logic signed [AW-1:0]  f1_yaw_r;
  logic signed [PTW-1:0] f1_pitch_r;
  dtyp_pkg::dtyp_tag_t   f1_tag_r;

  assign f1_yz_bias = cd_yz[ROT] + dtyp_pkg::ROUND_BIAS;
  assign f1_pz_bias = cd_pz[ROT] + dtyp_pkg::ROUND_BIAS;
  assign f1_yr      = $signed(f1_yz_bias[ZW-1:dtyp_pkg::FRAC_SHIFT]);
  assign f1_pr      = $signed(f1_pz_bias[ZW-1:dtyp_pkg::FRAC_SHIFT]);

  always_comb begin
    f1_yaw_w = (AW+1)'(f1_yr) - (AW+1)'(dtyp_pkg::QUARTER_TURN);
    if (f1_yaw_w < -dtyp_pkg::HALF_TURN) begin
      f1_yaw_w = f1_yaw_w + (AW+1)'(dtyp_pkg::FULL_TURN);
    end else if (f1_yaw_w >= dtyp_pkg::HALF_TURN) begin
      f1_yaw_w = f1_yaw_w - (AW+1)'(dtyp_pkg::FULL_TURN);
    end

    priority if (f1_pr > dtyp_pkg::QUARTER_TURN) begin
      f1_pitch_nxt = PTW'(dtyp_pkg::QUARTER_TURN);
    end else if (f1_pr < -dtyp_pkg::QUARTER_TURN) begin
      f1_pitch_nxt = PTW'(-dtyp_pkg::QUARTER_TURN);
    end else begin
      f1_pitch_nxt = PTW'(f1_pr);
    end
    f1_yaw_nxt = AW'(f1_yaw_w);

    // straight up or down: no horizontal direction
    if (cd_tag_r[ROT-1].vert) begin
      f1_yaw_nxt   = '0;
      f1_pitch_nxt = PTW'(-dtyp_pkg::QUARTER_TURN);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_yaw_r   <= f1_yaw_nxt;
      f1_pitch_r <= f1_pitch_nxt;
      f1_tag_r   <= cd_tag_r[ROT-1];
    end
  end

  // ---------------------------------------------------------------------
  // F2: cone test, 2*|angle - current| <= cone (no wrap across +-180)
  // ---------------------------------------------------------------------
  logic signed [AW+1:0]  f2_dyaw, f2_dpitch;
  logic signed [AW+2:0]  f2_dyaw2, f2_dpitch2, f2_cone;
  logic                  f2_cone_nxt;
  logic signed [AW-1:0]  f2_yaw_r;
  logic signed [PTW-1:0] f2_pitch_r;
  logic                  f2_cone_r;

  assign f2_dyaw    = (AW+2)'(f1_yaw_r) - (AW+2)'(f1_tag_r.cy);
  assign f2_dpitch  = (AW+2)'(f1_pitch_r) - (AW+2)'(f1_tag_r.cp);
  assign f2_dyaw2   = $signed({f2_dyaw, 1'b0});
  assign f2_dpitch2 = $signed({f2_dpitch, 1'b0});
  assign f2_cone    = $signed({3'b000, cone_r});
  assign f2_cone_nxt = (f2_dyaw2 >= -f2_cone) && (f2_dyaw2 <= f2_cone) &&
                       (f2_dpitch2 >= -f2_cone) && (f2_dpitch2 <= f2_cone);

  always_ff @(posedge clk) begin
    if (adv) begin
      f2_yaw_r   <= f1_yaw_r;
      f2_pitch_r <= f1_pitch_r;
      f2_cone_r  <= f2_cone_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // output register and skid register
  // ---------------------------------------------------------------------
  logic signed [AW-1:0]  out_yaw_r, skid_yaw_r;
  logic signed [PTW-1:0] out_pitch_r, skid_pitch_r;
  logic                  out_cone_r, skid_cone_r;

  assign out_load = !out_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_load) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= pv;
      end
    end else if (pv && adv) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_v_r) begin
        out_yaw_r   <= skid_yaw_r;
        out_pitch_r <= skid_pitch_r;
        out_cone_r  <= skid_cone_r;
      end else begin
        out_yaw_r   <= f2_yaw_r;
        out_pitch_r <= f2_pitch_r;
        out_cone_r  <= f2_cone_r;
      end
    end else if (adv) begin
      skid_yaw_r   <= f2_yaw_r;
      skid_pitch_r <= f2_pitch_r;
      skid_cone_r  <= f2_cone_r;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.yaw_out   = out_yaw_r;
  assign out_ch.pitch_out = out_pitch_r;
  assign out_ch.in_cone   = out_cone_r;

endmodule

`default_nettype wire

>>> design/dtyp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dtyp_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [dtyp_pkg::ANGLE_W-1:0] yaw,
  input wire logic signed [dtyp_pkg::PITCH_W-1:0] pitch
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(yaw) && $stable(pitch))
    else $error("result changed while stalled");

  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (yaw >= -dtyp_pkg::HALF_TURN) && (yaw < dtyp_pkg::HALF_TURN))
    else $error("yaw out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pitch >= -dtyp_pkg::QUARTER_TURN) && (pitch <= dtyp_pkg::QUARTER_TURN))
    else $error("pitch out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not empty after reset");

endmodule

bind direction_to_yaw_pitch_cone_test dtyp_checker u_dtyp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .yaw       (out_ch.yaw_out),
  .pitch     (out_ch.pitch_out)
);

`default_nettype wire
